FILE: design/delta_list_timer_queue_defines.svh
// Assertion macros for the delta-list timer queue.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define DLTQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dltq: check failed");

// Next-cycle implication
`define DLTQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dltq: check failed");

`else

`define DLTQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DLTQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: design/dltq_pkg.sv
`default_nettype none

package dltq_pkg;

  // Fixed field widths of the request and result beats
  localparam int ID_W        = 4;
  localparam int VAL_W       = 32;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_ADD,
    REQ_CANCEL,
    REQ_GET
  } req_t;

  typedef enum logic [2:0] {
    KIND_DONE,
    KIND_EXP_ASYNC,
    KIND_EXP_APP,
    KIND_REMAIN,
    KIND_READYQ
  } kind_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_UL_RD,
    S_UL_EV,
    S_UL_FIXRD,
    S_UL_FIX,
    S_ADD_SET,
    S_IN_RD,
    S_IN_EV,
    S_IN_LINK,
    S_IN_PREV,
    S_IN_CUR,
    S_GET_RD,
    S_GET_EV,
    S_TK_START,
    S_TK_DEC,
    S_TK_RD,
    S_TK_EV,
    S_TK_END,
    S_EMIT
  } state_t;

  // Field write enables of the slot memory
  typedef struct packed {
    logic delta;
    logic link;
    logic mode;
  } mem_we_t;

  // One result beat
  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] value;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

FILE: design/delta_list_timer_queue.sv
`default_nettype none

// Delta-list timer queue of numbered alarms.
// Input channel (in_valid/in_stall): one request beat: tick, add, cancel or get.
// Output channel (out_valid/out_stall): result beats; out_last marks the final
// beat of a request. A tick gives one beat per expired alarm (at most 16), or
// a single done beat; every other request gives exactly one beat.
// One request is worked on at a time; in_stall is high until the sequencer has
// handed the request's final beat to the output register.
// Each list node visited is a memory read, then an evaluate. Get walks to
// the alarm; cancel of a listed alarm walks to it and unlinks it, fixing
// the successor's delta when it has one, while cancel of an unlisted one
// answers without a walk. Add first unlinks an already listed alarm, then
// stores its mode and inserts it (unless delay and reload are both zero)
// and answers. A tick decrements the head of a non-empty list, then pops
// each expired alarm, with an insert walk per reloaded alarm.
// Reset (rst_n low, synchronous) empties the list and marks every alarm not
// listed; slot memory needs no clearing pass, so the block is ready at once.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits at its next result until the register is free.
module delta_list_timer_queue #(
  parameter int NUM_ALARMS = 16,
  parameter int TICK_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [dltq_pkg::ID_W-1:0]  in_alarm_id,
  input  logic [dltq_pkg::VAL_W-1:0] in_delay_ticks,
  input  logic [dltq_pkg::VAL_W-1:0] in_reload_ticks,
  input  logic                       in_is_async,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 out_kind,
  output logic [dltq_pkg::ID_W-1:0]  out_alarm_id_res,
  output logic [dltq_pkg::VAL_W-1:0] out_value,
  output logic                       out_last
);

  localparam int SLOT_W = $clog2(NUM_ALARMS);

  logic                  idle;
  logic                  emit_ok;
  logic                  res_load;
  dltq_pkg::res_t        res;

  logic                  rd_en;
  logic [SLOT_W-1:0]     rd_addr;
  logic [TICK_WIDTH-1:0] rd_delta;
  logic                  rd_link_v;
  logic [SLOT_W-1:0]     rd_link;
  logic [TICK_WIDTH-1:0] rd_reload;
  logic                  rd_async;
  dltq_pkg::mem_we_t     we;
  logic [SLOT_W-1:0]     wr_addr;
  logic [TICK_WIDTH-1:0] wr_delta;
  logic                  wr_link_v;
  logic [SLOT_W-1:0]     wr_link;
  logic [TICK_WIDTH-1:0] wr_reload;
  logic                  wr_async;

  dltq_pkg::alu_op_t     alu_op;
  logic [TICK_WIDTH-1:0] alu_a;
  logic [TICK_WIDTH-1:0] alu_b;
  logic [TICK_WIDTH-1:0] alu_res;
  logic                  alu_borrow;
  logic                  alu_zero;

  logic                  out_valid_r;
  dltq_pkg::res_t        out_res_r;

  dltq_seq #(
    .NUM_ALARMS (NUM_ALARMS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_req_type     (in_req_type),
    .in_alarm_id     (in_alarm_id),
    .in_delay_ticks  (in_delay_ticks),
    .in_reload_ticks (in_reload_ticks),
    .in_is_async     (in_is_async),
    .idle            (idle),
    .emit_ok         (emit_ok),
    .res_load        (res_load),
    .res             (res),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_delta        (rd_delta),
    .rd_link_v       (rd_link_v),
    .rd_link         (rd_link),
    .rd_reload       (rd_reload),
    .rd_async        (rd_async),
    .we              (we),
    .wr_addr         (wr_addr),
    .wr_delta        (wr_delta),
    .wr_link_v       (wr_link_v),
    .wr_link         (wr_link),
    .wr_reload       (wr_reload),
    .wr_async        (wr_async),
    .alu_op          (alu_op),
    .alu_a           (alu_a),
    .alu_b           (alu_b),
    .alu_res         (alu_res),
    .alu_borrow      (alu_borrow),
    .alu_zero        (alu_zero)
  );

  dltq_mem #(
    .NUM_ALARMS (NUM_ALARMS),
    .TICK_WIDTH (TICK_WIDTH)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_delta  (rd_delta),
    .rd_link_v (rd_link_v),
    .rd_link   (rd_link),
    .rd_reload (rd_reload),
    .rd_async  (rd_async),
    .we        (we),
    .wr_addr   (wr_addr),
    .wr_delta  (wr_delta),
    .wr_link_v (wr_link_v),
    .wr_link   (wr_link),
    .wr_reload (wr_reload),
    .wr_async  (wr_async)
  );

  dltq_alu #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  // Request side is held off while a request is in work
  assign in_stall = !idle;

  // Output register: free when empty or when its beat leaves this cycle
  assign emit_ok = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_alarm_id_res = out_res_r.id;
  assign out_value        = out_res_r.value;
  assign out_last         = out_res_r.last;

endmodule

`default_nettype wire

FILE: design/dltq_alu.sv
`default_nettype none

// Shared add/subtract unit; borrow flags a < b on subtract
module dltq_alu #(
  parameter int TICK_WIDTH = 32
) (
  input  dltq_pkg::alu_op_t        op,
  input  logic [TICK_WIDTH-1:0]    a,
  input  logic [TICK_WIDTH-1:0]    b,
  output logic [TICK_WIDTH-1:0]    res,
  output logic                     borrow,
  output logic                     zero
);

  logic [TICK_WIDTH:0] sum;

  always_comb begin
    case (op)
      dltq_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
      dltq_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
      default:           sum = '0;
    endcase
  end

  assign res    = sum[TICK_WIDTH-1:0];
  assign borrow = (op == dltq_pkg::ALU_SUB) && sum[TICK_WIDTH];
  assign zero   = (res == '0);

endmodule

`default_nettype wire

FILE: design/dltq_mem.sv
`default_nettype none

// Per-slot storage: delta, successor link, reload period, async flag.
// One write address and one read address per cycle, registered read data.
module dltq_mem #(
  parameter int NUM_ALARMS = 16,
  parameter int TICK_WIDTH = 32,
  localparam int SLOT_W = $clog2(NUM_ALARMS)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [SLOT_W-1:0]     rd_addr,
  output logic [TICK_WIDTH-1:0] rd_delta,
  output logic                  rd_link_v,
  output logic [SLOT_W-1:0]     rd_link,
  output logic [TICK_WIDTH-1:0] rd_reload,
  output logic                  rd_async,
  input  dltq_pkg::mem_we_t     we,
  input  logic [SLOT_W-1:0]     wr_addr,
  input  logic [TICK_WIDTH-1:0] wr_delta,
  input  logic                  wr_link_v,
  input  logic [SLOT_W-1:0]     wr_link,
  input  logic [TICK_WIDTH-1:0] wr_reload,
  input  logic                  wr_async
);

  logic [TICK_WIDTH-1:0] delta_mem  [NUM_ALARMS];
  logic [SLOT_W:0]       link_mem   [NUM_ALARMS];
  logic [TICK_WIDTH-1:0] reload_mem [NUM_ALARMS];
  logic                  async_mem  [NUM_ALARMS];

  logic [TICK_WIDTH-1:0] rd_delta_r;
  logic [SLOT_W:0]       rd_link_r;
  logic [TICK_WIDTH-1:0] rd_reload_r;
  logic                  rd_async_r;

  // Field-enabled write port
  always_ff @(posedge clk) begin
    if (we.delta) delta_mem[wr_addr] <= wr_delta;
    if (we.link) link_mem[wr_addr] <= {wr_link_v, wr_link};
    if (we.mode) begin
      reload_mem[wr_addr] <= wr_reload;
      async_mem[wr_addr]  <= wr_async;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_delta_r  <= delta_mem[rd_addr];
      rd_link_r   <= link_mem[rd_addr];
      rd_reload_r <= reload_mem[rd_addr];
      rd_async_r  <= async_mem[rd_addr];
    end
  end

  assign rd_delta  = rd_delta_r;
  assign rd_link_v = rd_link_r[SLOT_W];
  assign rd_link   = rd_link_r[SLOT_W-1:0];
  assign rd_reload = rd_reload_r;
  assign rd_async  = rd_async_r;

endmodule

`default_nettype wire

FILE: design/dltq_seq.sv
`default_nettype none
`include "delta_list_timer_queue_defines.svh"

// Request sequencer: walks the delta list one node per read/evaluate pair,
// driving the slot memory and the shared add/subtract unit.
module dltq_seq #(
  parameter int NUM_ALARMS = 16,
  parameter int TICK_WIDTH = 32,
  localparam int SLOT_W = $clog2(NUM_ALARMS)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [1:0]                     in_req_type,
  input  logic [dltq_pkg::ID_W-1:0]      in_alarm_id,
  input  logic [dltq_pkg::VAL_W-1:0]     in_delay_ticks,
  input  logic [dltq_pkg::VAL_W-1:0]     in_reload_ticks,
  input  logic                           in_is_async,
  output logic                           idle,
  input  logic                           emit_ok,
  output logic                           res_load,
  output dltq_pkg::res_t                 res,
  output logic                           rd_en,
  output logic [SLOT_W-1:0]              rd_addr,
  input  logic [TICK_WIDTH-1:0]          rd_delta,
  input  logic                           rd_link_v,
  input  logic [SLOT_W-1:0]              rd_link,
  input  logic [TICK_WIDTH-1:0]          rd_reload,
  input  logic                           rd_async,
  output dltq_pkg::mem_we_t              we,
  output logic [SLOT_W-1:0]              wr_addr,
  output logic [TICK_WIDTH-1:0]          wr_delta,
  output logic                           wr_link_v,
  output logic [SLOT_W-1:0]              wr_link,
  output logic [TICK_WIDTH-1:0]          wr_reload,
  output logic                           wr_async,
  output dltq_pkg::alu_op_t              alu_op,
  output logic [TICK_WIDTH-1:0]          alu_a,
  output logic [TICK_WIDTH-1:0]          alu_b,
  input  logic [TICK_WIDTH-1:0]          alu_res,
  input  logic                           alu_borrow,
  input  logic                           alu_zero
);

  localparam int STEP_W = $clog2(NUM_ALARMS + 1);

  dltq_pkg::state_t state_r, state_nxt;
  dltq_pkg::state_t cont_r, cont_nxt;

  logic                      head_v_r, head_v_nxt;
  logic [SLOT_W-1:0]         head_r, head_nxt;
  logic [NUM_ALARMS-1:0]     listed_r, listed_nxt;
  logic                      cur_v_r, cur_v_nxt;
  logic [SLOT_W-1:0]         cur_r, cur_nxt;
  logic                      prev_v_r, prev_v_nxt;
  logic [SLOT_W-1:0]         prev_r, prev_nxt;
  logic [SLOT_W-1:0]         tgt_r, tgt_nxt;
  logic [STEP_W-1:0]         steps_r, steps_nxt;
  logic [TICK_WIDTH-1:0]     acc_r, acc_nxt;
  logic [TICK_WIDTH-1:0]     t_r, t_nxt;
  logic [TICK_WIDTH-1:0]     rel_r, rel_nxt;
  logic                      async_r, async_nxt;
  dltq_pkg::res_t            res_r, res_nxt;
  logic                      pend_v_r, pend_v_nxt;
  dltq_pkg::kind_t           pend_kind_r, pend_kind_nxt;
  logic [SLOT_W-1:0]         pend_id_r, pend_id_nxt;
  logic [dltq_pkg::CNT_W-1:0] n_r, n_nxt;

  // Request decode
  dltq_pkg::req_t        req_in;
  logic                  in_range;
  logic [SLOT_W-1:0]     id_slot;
  logic                  listed_in;
  logic [TICK_WIDTH-1:0] in_t;
  logic [TICK_WIDTH-1:0] in_rel;
  logic [TICK_WIDTH-1:0] t_in;

  assign req_in    = dltq_pkg::req_t'(in_req_type);
  assign in_range  = 32'(in_alarm_id) < 32'(NUM_ALARMS);
  assign id_slot   = SLOT_W'(in_alarm_id);
  assign listed_in = in_range && listed_r[id_slot];
  assign in_t      = TICK_WIDTH'(in_delay_ticks);
  assign in_rel    = TICK_WIDTH'(in_reload_ticks);
  assign t_in      = (in_t != '0) ? in_t : in_rel;

  // Walk conditions
  logic walk_ok, hit, ins_go, rel_nz, tk_room, reinsert;

  assign walk_ok  = cur_v_r && (steps_r != STEP_W'(NUM_ALARMS));
  assign hit      = (cur_r == tgt_r);
  assign ins_go   = !alu_borrow && !alu_zero;
  assign rel_nz   = (rd_reload != '0);
  assign tk_room  = n_r < dltq_pkg::CNT_W'(dltq_pkg::MAX_RESULTS);
  assign reinsert = rd_async && rel_nz;

  assign idle = (state_r == dltq_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dltq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (req_in == dltq_pkg::REQ_TICK) begin
            state_nxt = dltq_pkg::S_TK_START;
          end else if (!in_range) begin
            state_nxt = dltq_pkg::S_EMIT;
          end else begin
            case (req_in)
              dltq_pkg::REQ_ADD:
                state_nxt = listed_in ? dltq_pkg::S_UL_RD : dltq_pkg::S_ADD_SET;
              dltq_pkg::REQ_CANCEL:
                state_nxt = listed_in ? dltq_pkg::S_UL_RD : dltq_pkg::S_EMIT;
              default:
                state_nxt = dltq_pkg::S_GET_RD;
            endcase
          end
        end
      end
      dltq_pkg::S_UL_RD:    state_nxt = walk_ok ? dltq_pkg::S_UL_EV : cont_r;
      dltq_pkg::S_UL_EV: begin
        if (hit) state_nxt = rd_link_v ? dltq_pkg::S_UL_FIXRD : cont_r;
        else     state_nxt = dltq_pkg::S_UL_RD;
      end
      dltq_pkg::S_UL_FIXRD: state_nxt = dltq_pkg::S_UL_FIX;
      dltq_pkg::S_UL_FIX:   state_nxt = cont_r;
      dltq_pkg::S_ADD_SET:
        state_nxt = (t_r == '0) ? dltq_pkg::S_EMIT : dltq_pkg::S_IN_RD;
      dltq_pkg::S_IN_RD:    state_nxt = walk_ok ? dltq_pkg::S_IN_EV : dltq_pkg::S_IN_LINK;
      dltq_pkg::S_IN_EV:    state_nxt = ins_go ? dltq_pkg::S_IN_RD : dltq_pkg::S_IN_LINK;
      dltq_pkg::S_IN_LINK:  state_nxt = dltq_pkg::S_IN_PREV;
      dltq_pkg::S_IN_PREV:  state_nxt = dltq_pkg::S_IN_CUR;
      dltq_pkg::S_IN_CUR:   state_nxt = cont_r;
      dltq_pkg::S_GET_RD:   state_nxt = walk_ok ? dltq_pkg::S_GET_EV : dltq_pkg::S_EMIT;
      dltq_pkg::S_GET_EV:   state_nxt = hit ? dltq_pkg::S_EMIT : dltq_pkg::S_GET_RD;
      dltq_pkg::S_TK_START:
        state_nxt = head_v_r ? dltq_pkg::S_TK_DEC : dltq_pkg::S_TK_END;
      dltq_pkg::S_TK_DEC:   state_nxt = dltq_pkg::S_TK_RD;
      dltq_pkg::S_TK_RD:
        state_nxt = (tk_room && head_v_r) ? dltq_pkg::S_TK_EV : dltq_pkg::S_TK_END;
      dltq_pkg::S_TK_EV: begin
        if (!alu_zero)                state_nxt = dltq_pkg::S_TK_END;
        else if (pend_v_r && !emit_ok) state_nxt = dltq_pkg::S_TK_EV;
        else if (reinsert)            state_nxt = dltq_pkg::S_IN_RD;
        else                          state_nxt = dltq_pkg::S_TK_RD;
      end
      dltq_pkg::S_TK_END:   state_nxt = emit_ok ? dltq_pkg::S_IDLE : dltq_pkg::S_TK_END;
      dltq_pkg::S_EMIT:     state_nxt = emit_ok ? dltq_pkg::S_IDLE : dltq_pkg::S_EMIT;
      default:              state_nxt = dltq_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory, unit and result controls
  always_comb begin
    cont_nxt      = cont_r;
    head_v_nxt    = head_v_r;
    head_nxt      = head_r;
    listed_nxt    = listed_r;
    cur_v_nxt     = cur_v_r;
    cur_nxt       = cur_r;
    prev_v_nxt    = prev_v_r;
    prev_nxt      = prev_r;
    tgt_nxt       = tgt_r;
    steps_nxt     = steps_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    rel_nxt       = rel_r;
    async_nxt     = async_r;
    res_nxt       = res_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_id_nxt   = pend_id_r;
    n_nxt         = n_r;

    rd_en     = 1'b0;
    rd_addr   = cur_r;
    we        = '0;
    wr_addr   = cur_r;
    wr_delta  = alu_res;
    wr_link_v = cur_v_r;
    wr_link   = cur_r;
    wr_reload = rel_r;
    wr_async  = async_r;
    alu_op    = dltq_pkg::ALU_ADD;
    alu_a     = rd_delta;
    alu_b     = acc_r;
    res_load  = 1'b0;
    res       = res_r;

    case (state_r)
      // Latch the request and set up the walk from the head
      dltq_pkg::S_IDLE: begin
        if (in_valid) begin
          tgt_nxt       = id_slot;
          t_nxt         = t_in;
          rel_nxt       = in_rel;
          async_nxt     = in_is_async;
          cur_v_nxt     = head_v_r;
          cur_nxt       = head_r;
          prev_v_nxt    = 1'b0;
          steps_nxt     = '0;
          acc_nxt       = '0;
          n_nxt         = '0;
          pend_v_nxt    = 1'b0;
          res_nxt.kind  = dltq_pkg::KIND_DONE;
          res_nxt.id    = in_alarm_id;
          res_nxt.value = '0;
          res_nxt.last  = 1'b1;
          if (in_range) begin
            if (req_in == dltq_pkg::REQ_CANCEL && !listed_in)
              res_nxt.kind = dltq_pkg::KIND_READYQ;
            if (req_in == dltq_pkg::REQ_GET)
              res_nxt.kind = dltq_pkg::KIND_REMAIN;
          end
          cont_nxt = (req_in == dltq_pkg::REQ_ADD) ? dltq_pkg::S_ADD_SET : dltq_pkg::S_EMIT;
        end
      end

      // Unlink: find the target, bypass it, fold its delta into the successor
      dltq_pkg::S_UL_RD: begin
        if (walk_ok) rd_en = 1'b1;
        else         listed_nxt[tgt_r] = 1'b0;
      end
      dltq_pkg::S_UL_EV: begin
        cur_v_nxt = rd_link_v;
        cur_nxt   = rd_link;
        if (hit) begin
          if (prev_v_r) begin
            we.link   = 1'b1;
            wr_addr   = prev_r;
            wr_link_v = rd_link_v;
            wr_link   = rd_link;
          end else begin
            head_v_nxt = rd_link_v;
            head_nxt   = rd_link;
          end
          acc_nxt = rd_delta;
          if (!rd_link_v) listed_nxt[tgt_r] = 1'b0;
        end else begin
          prev_v_nxt = 1'b1;
          prev_nxt   = cur_r;
          steps_nxt  = steps_r + STEP_W'(1);
        end
      end
      dltq_pkg::S_UL_FIXRD: rd_en = 1'b1;
      dltq_pkg::S_UL_FIX: begin
        alu_op   = dltq_pkg::ALU_ADD;
        alu_a    = rd_delta;
        alu_b    = acc_r;
        we.delta = 1'b1;
        listed_nxt[tgt_r] = 1'b0;
      end

      // Add: store mode, then insert or expire at once
      dltq_pkg::S_ADD_SET: begin
        cont_nxt = dltq_pkg::S_EMIT;
        we.mode  = 1'b1;
        wr_addr  = tgt_r;
        if (t_r == '0) begin
          res_nxt.kind = dltq_pkg::KIND_EXP_APP;
        end else begin
          acc_nxt    = t_r;
          cur_v_nxt  = head_v_r;
          cur_nxt    = head_r;
          prev_v_nxt = 1'b0;
          steps_nxt  = '0;
        end
      end

      // Insert: skip nodes whose delta is below the remaining delay
      dltq_pkg::S_IN_RD: begin
        if (walk_ok) rd_en = 1'b1;
      end
      dltq_pkg::S_IN_EV: begin
        alu_op = dltq_pkg::ALU_SUB;
        alu_a  = acc_r;
        alu_b  = rd_delta;
        if (ins_go) begin
          acc_nxt    = alu_res;
          prev_v_nxt = 1'b1;
          prev_nxt   = cur_r;
          cur_v_nxt  = rd_link_v;
          cur_nxt    = rd_link;
          steps_nxt  = steps_r + STEP_W'(1);
        end
      end
      dltq_pkg::S_IN_LINK: begin
        we.delta  = 1'b1;
        we.link   = 1'b1;
        wr_addr   = tgt_r;
        wr_delta  = acc_r;
        wr_link_v = cur_v_r;
        wr_link   = cur_r;
        listed_nxt[tgt_r] = 1'b1;
      end
      dltq_pkg::S_IN_PREV: begin
        if (prev_v_r) begin
          we.link   = 1'b1;
          wr_addr   = prev_r;
          wr_link_v = 1'b1;
          wr_link   = tgt_r;
        end else begin
          head_v_nxt = 1'b1;
          head_nxt   = tgt_r;
        end
      end
      dltq_pkg::S_IN_CUR: begin
        alu_op = dltq_pkg::ALU_SUB;
        alu_a  = rd_delta;
        alu_b  = acc_r;
        if (cur_v_r) we.delta = 1'b1;
      end

      // Get: running sum up to the named alarm
      dltq_pkg::S_GET_RD: begin
        if (walk_ok) rd_en = 1'b1;
      end
      dltq_pkg::S_GET_EV: begin
        alu_op  = dltq_pkg::ALU_ADD;
        alu_a   = acc_r;
        alu_b   = rd_delta;
        acc_nxt = alu_res;
        if (hit) begin
          res_nxt.value = dltq_pkg::VAL_W'(alu_res);
        end else begin
          cur_v_nxt = rd_link_v;
          cur_nxt   = rd_link;
          steps_nxt = steps_r + STEP_W'(1);
        end
      end

      // Tick: saturating decrement of the head
      dltq_pkg::S_TK_START: begin
        rd_en   = head_v_r;
        rd_addr = head_r;
      end
      dltq_pkg::S_TK_DEC: begin
        alu_op  = dltq_pkg::ALU_SUB;
        alu_a   = rd_delta;
        alu_b   = TICK_WIDTH'(1);
        wr_addr = head_r;
        if (!alu_borrow) we.delta = 1'b1;
      end
      dltq_pkg::S_TK_RD: begin
        rd_en   = tk_room && head_v_r;
        rd_addr = head_r;
      end

      // Pop a head at zero; previous expiry goes out once a later one exists
      dltq_pkg::S_TK_EV: begin
        alu_op = dltq_pkg::ALU_SUB;
        alu_a  = rd_delta;
        alu_b  = '0;
        if (alu_zero && (!pend_v_r || emit_ok)) begin
          if (pend_v_r) begin
            res_load   = 1'b1;
            res.kind   = pend_kind_r;
            res.id     = dltq_pkg::ID_W'(pend_id_r);
            res.value  = '0;
            res.last   = 1'b0;
          end
          pend_v_nxt    = 1'b1;
          pend_kind_nxt = rd_async ? dltq_pkg::KIND_EXP_ASYNC : dltq_pkg::KIND_EXP_APP;
          pend_id_nxt   = head_r;
          head_v_nxt    = rd_link_v;
          head_nxt      = rd_link;
          listed_nxt[head_r] = 1'b0;
          n_nxt         = n_r + dltq_pkg::CNT_W'(1);
          if (reinsert) begin
            tgt_nxt    = head_r;
            acc_nxt    = rd_reload;
            cur_v_nxt  = rd_link_v;
            cur_nxt    = rd_link;
            prev_v_nxt = 1'b0;
            steps_nxt  = '0;
            cont_nxt   = dltq_pkg::S_TK_RD;
          end
        end
      end
      dltq_pkg::S_TK_END: begin
        if (emit_ok) begin
          res_load  = 1'b1;
          res.value = '0;
          res.last  = 1'b1;
          if (pend_v_r) begin
            res.kind = pend_kind_r;
            res.id   = dltq_pkg::ID_W'(pend_id_r);
          end else begin
            res.kind = dltq_pkg::KIND_DONE;
            res.id   = '0;
          end
        end
      end

      dltq_pkg::S_EMIT: begin
        res_load = emit_ok;
      end

      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dltq_pkg::S_IDLE;
      head_v_r <= 1'b0;
      listed_r <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_v_r <= head_v_nxt;
      listed_r <= listed_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  // Walk and payload registers
  always_ff @(posedge clk) begin
    cont_r      <= cont_nxt;
    head_r      <= head_nxt;
    cur_v_r     <= cur_v_nxt;
    cur_r       <= cur_nxt;
    prev_v_r    <= prev_v_nxt;
    prev_r      <= prev_nxt;
    tgt_r       <= tgt_nxt;
    steps_r     <= steps_nxt;
    acc_r       <= acc_nxt;
    t_r         <= t_nxt;
    rel_r       <= rel_nxt;
    async_r     <= async_nxt;
    res_r       <= res_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_id_r   <= pend_id_nxt;
    n_r         <= n_nxt;
  end

  // A result is only produced when the output register can take it
  `DLTQ_ASSERT_IMP(a_emit_room, clk, rst_n, res_load, emit_ok)
  // The head of the list is always a listed alarm
  `DLTQ_ASSERT_IMP(a_head_listed, clk, rst_n, head_v_r, listed_r[head_r])
  // A listed alarm is always reached before the walk runs off the list
  `DLTQ_ASSERT_IMP(a_unlink_finds, clk, rst_n,
                   (state_r == dltq_pkg::S_UL_RD) && listed_r[tgt_r], cur_v_r)
  // Fixing the successor's delta finishes the unlink
  `DLTQ_ASSERT_NXT(a_unlink_done, clk, rst_n,
                   state_r == dltq_pkg::S_UL_FIX, !listed_r[tgt_r])

endmodule

`default_nettype wire

FILE: tb/dltq_result_checker.sv
`timescale 1ns / 100ps

// Result checker for the delta-list timer queue.
// Watches both channels, keeps its own copy of the alarm list, queues the
// beats each accepted request should produce and compares every result beat.
module dltq_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [dltq_pkg::ID_W-1:0]  in_alarm_id,
  input  logic [dltq_pkg::VAL_W-1:0] in_delay_ticks,
  input  logic [dltq_pkg::VAL_W-1:0] in_reload_ticks,
  input  logic                       in_is_async,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [2:0]                 out_kind,
  input  logic [dltq_pkg::ID_W-1:0]  out_alarm_id_res,
  input  logic [dltq_pkg::VAL_W-1:0] out_value,
  input  logic                       out_last,
  output int                         fail_count,
  output int                         pending
);

  localparam int SLOTS = 16;
  localparam int VW    = dltq_pkg::VAL_W;
  localparam logic [4:0] NO_SLOT = 5'(SLOTS);

  // Shadow alarm list
  logic [VW-1:0] rel_ticks [SLOTS];
  logic [4:0]    link      [SLOTS];
  logic          armed     [SLOTS];
  logic [VW-1:0] period    [SLOTS];
  logic          async_mode[SLOTS];
  logic [4:0]    first_slot;

  dltq_pkg::res_t expected_beats[$];
  int             mismatches = 0;

  function automatic void push_beat(input dltq_pkg::kind_t kind,
                                    input logic [dltq_pkg::ID_W-1:0] id,
                                    input logic [VW-1:0] value, input logic last);
    dltq_pkg::res_t beat;
    beat.kind  = kind;
    beat.id    = id;
    beat.value = value;
    beat.last  = last;
    expected_beats.push_back(beat);
  endfunction

  // Take an alarm out of the chain; its delta moves to its successor
  function automatic void unlink_slot(input logic [4:0] id);
    logic [4:0] prev;
    logic [4:0] cur;
    logic [4:0] nx;
    int         steps;
    logic       found;
    prev  = NO_SLOT;
    cur   = first_slot;
    steps = 0;
    found = 1'b0;
    while (!found && steps < SLOTS && cur < NO_SLOT) begin
      if (cur == id) begin
        nx = link[cur];
        if (prev < NO_SLOT) link[prev] = nx;
        else first_slot = nx;
        if (nx < NO_SLOT) rel_ticks[nx] = rel_ticks[nx] + rel_ticks[cur];
        found = 1'b1;
      end else begin
        prev = cur;
        cur  = link[cur];
        steps++;
      end
    end
    armed[id] = 1'b0;
  endfunction

  // Sorted insert at absolute delay t (t > 0); a new alarm goes ahead of equal ones
  function automatic void insert_slot(input logic [4:0] id, input logic [VW-1:0] t);
    logic [4:0] prev;
    logic [4:0] cur;
    int         steps;
    prev  = NO_SLOT;
    cur   = first_slot;
    steps = 0;
    while (steps < SLOTS && cur < NO_SLOT && rel_ticks[cur] < t) begin
      t    = t - rel_ticks[cur];
      prev = cur;
      cur  = link[cur];
      steps++;
    end
    link[id] = cur;
    if (prev < NO_SLOT) link[prev] = id;
    else first_slot = id;
    if (cur < NO_SLOT) rel_ticks[cur] = rel_ticks[cur] - t;
    rel_ticks[id] = t;
    armed[id]     = 1'b1;
  endfunction

  // Advance the shadow list by one request and queue its result beats
  function automatic void predict_request(input dltq_pkg::req_t req,
                                          input logic [dltq_pkg::ID_W-1:0] id,
                                          input logic [VW-1:0] delay,
                                          input logic [VW-1:0] reload,
                                          input logic async_in);
    logic [4:0]    slot;
    logic [4:0]    a;
    logic [4:0]    cur;
    logic [VW-1:0] sum;
    logic [VW-1:0] remain;
    int            n;
    int            steps;
    logic          found;
    slot = {1'b0, id};
    case (req)
      dltq_pkg::REQ_TICK: begin
        if (first_slot < NO_SLOT && rel_ticks[first_slot] != 0)
          rel_ticks[first_slot] = rel_ticks[first_slot] - 1;
        n = 0;
        while (n < dltq_pkg::MAX_RESULTS && first_slot < NO_SLOT &&
               rel_ticks[first_slot] == 0) begin
          a          = first_slot;
          first_slot = link[a];
          armed[a]   = 1'b0;
          push_beat(async_mode[a] ? dltq_pkg::KIND_EXP_ASYNC : dltq_pkg::KIND_EXP_APP,
                    a[dltq_pkg::ID_W-1:0], '0, 1'b0);
          n++;
          if (async_mode[a] && period[a] != 0) insert_slot(a, period[a]);
        end
        if (n == 0) push_beat(dltq_pkg::KIND_DONE, '0, '0, 1'b1);
        else expected_beats[expected_beats.size() - 1].last = 1'b1;
      end
      dltq_pkg::REQ_ADD: begin
        if (armed[slot]) unlink_slot(slot);
        period[slot]     = reload;
        async_mode[slot] = async_in;
        if (delay == 0) delay = reload;
        if (delay != 0) begin
          insert_slot(slot, delay);
          push_beat(dltq_pkg::KIND_DONE, id, '0, 1'b1);
        end else begin
          // nothing to wait for: straight to the ready queue
          push_beat(dltq_pkg::KIND_EXP_APP, id, '0, 1'b1);
        end
      end
      dltq_pkg::REQ_CANCEL: begin
        if (armed[slot]) begin
          unlink_slot(slot);
          push_beat(dltq_pkg::KIND_DONE, id, '0, 1'b1);
        end else begin
          push_beat(dltq_pkg::KIND_READYQ, id, '0, 1'b1);
        end
      end
      default: begin
        // get: running sum of deltas up to the alarm, 0 if not listed
        sum    = '0;
        remain = '0;
        cur    = first_slot;
        steps  = 0;
        found  = 1'b0;
        while (!found && steps < SLOTS && cur < NO_SLOT) begin
          sum = sum + rel_ticks[cur];
          if (cur == slot) begin
            remain = sum;
            found  = 1'b1;
          end else begin
            cur = link[cur];
            steps++;
          end
        end
        push_beat(dltq_pkg::KIND_REMAIN, id, remain, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(input string what, input logic [VW-1:0] want,
                                      input logic [VW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    dltq_pkg::res_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) armed[i] = 1'b0;
      first_slot = NO_SLOT;
      expected_beats.delete();
    end else begin
      // request beat accepted: predict first, its results come later
      if (in_valid && !in_stall)
        predict_request(dltq_pkg::req_t'(in_req_type), in_alarm_id, in_delay_ticks,
                        in_reload_ticks, in_is_async);
      // result beat accepted: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected: kind %0d id %0d value %0h last %0d",
                   $time, out_kind, out_alarm_id_res, out_value, out_last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", VW'(want.kind), VW'(out_kind));
          check_field("alarm_id_res", VW'(want.id), VW'(out_alarm_id_res));
          check_field("value", want.value, out_value);
          check_field("last", VW'(want.last), VW'(out_last));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_beats.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the delta-list timer queue.
module testbench;

  localparam int RANDOM_END  = 340;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 100;
  localparam int IW          = dltq_pkg::ID_W;
  localparam int VW          = dltq_pkg::VAL_W;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [1:0]    in_req_type;
  logic [IW-1:0] in_alarm_id;
  logic [VW-1:0] in_delay_ticks;
  logic [VW-1:0] in_reload_ticks;
  logic          in_is_async;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [2:0]    out_kind;
  logic [IW-1:0] out_alarm_id_res;
  logic [VW-1:0] out_value;
  logic          out_last;
  int            fail_count;
  int            pending;

  int          items_sent = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase_left = 0;

  delta_list_timer_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_alarm_id     (in_alarm_id),
    .in_delay_ticks  (in_delay_ticks),
    .in_reload_ticks (in_reload_ticks),
    .in_is_async     (in_is_async),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_alarm_id_res(out_alarm_id_res),
    .out_value       (out_value),
    .out_last        (out_last)
  );

  dltq_result_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_alarm_id     (in_alarm_id),
    .in_delay_ticks  (in_delay_ticks),
    .in_reload_ticks (in_reload_ticks),
    .in_is_async     (in_is_async),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_alarm_id_res(out_alarm_id_res),
    .out_value       (out_value),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: stall style is picked at random for each phase
  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= stall_mode_t'($urandom_range(0, 3));
      stall_phase_left <= $urandom_range(20, 200);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_phase_left % 8) < 3);
    endcase
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** delta_list_timer_queue: FAILED **");
    $finish;
  end

  // Mostly short delays so alarms do expire; sometimes zero or full width
  function automatic logic [VW-1:0] rand_ticks();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return $urandom;
    return $urandom_range(1, 6);
  endfunction

  // One request beat; the sender may pause between bursts
  task automatic send_req(input dltq_pkg::req_t req, input logic [IW-1:0] id,
                          input logic [VW-1:0] delay, input logic [VW-1:0] reload,
                          input logic async_in);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_alarm_id     <= id;
    in_delay_ticks  <= delay;
    in_reload_ticks <= reload;
    in_is_async     <= async_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Tick with junk in the ignored fields
  task automatic send_tick();
    send_req(dltq_pkg::REQ_TICK, IW'($urandom), $urandom, $urandom, 1'($urandom));
  endtask

  initial begin
    int scen;
    int count;
    int base;
    int same_delay;
    int pick;
    logic [IW-1:0] id_sel;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = dltq_pkg::REQ_TICK;
    in_alarm_id     = '0;
    in_delay_ticks  = '0;
    in_reload_ticks = '0;
    in_is_async     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, immediate expiry, extremes, ordering, re-add
    send_tick();
    send_req(dltq_pkg::REQ_GET, 4'd5, '0, '0, 1'b0);
    send_req(dltq_pkg::REQ_CANCEL, 4'd5, '0, '0, 1'b0);
    send_req(dltq_pkg::REQ_ADD, 4'd0, '0, '0, 1'b1);      // zero delay, no reload
    send_req(dltq_pkg::REQ_ADD, 4'd15, '1, '1, 1'b1);     // longest delay and period
    send_req(dltq_pkg::REQ_ADD, 4'd1, 32'd3, '0, 1'b0);
    send_req(dltq_pkg::REQ_ADD, 4'd2, 32'd3, '0, 1'b1);   // equal delay lands ahead
    send_req(dltq_pkg::REQ_ADD, 4'd3, '0, 32'd2, 1'b1);   // delay taken from reload
    send_req(dltq_pkg::REQ_GET, 4'd15, '0, '0, 1'b0);
    send_req(dltq_pkg::REQ_GET, 4'd2, '0, '0, 1'b0);
    send_req(dltq_pkg::REQ_ADD, 4'd1, 32'd1, '0, 1'b0);   // already listed
    send_req(dltq_pkg::REQ_CANCEL, 4'd2, '0, '0, 1'b0);
    repeat (4) send_tick();
    send_req(dltq_pkg::REQ_CANCEL, 4'd15, '0, '0, 1'b0);
    send_req(dltq_pkg::REQ_GET, 4'd15, '0, '0, 1'b0);
    send_req(dltq_pkg::REQ_CANCEL, 4'd3, '0, '0, 1'b0);

    // Random mix of scenarios
    while (items_sent < RANDOM_END) begin
      scen = $urandom_range(0, 9);
      if (scen <= 1) begin
        // fill many slots, then tick through them
        count      = $urandom_range(4, 16);
        base       = $urandom_range(0, 15);
        same_delay = $urandom_range(0, 1);
        pick       = $urandom_range(1, 3);
        for (int k = 0; k < count; k++)
          send_req(dltq_pkg::REQ_ADD, IW'(base + k),
                   same_delay ? VW'(pick) : VW'($urandom_range(1, 5)),
                   $urandom_range(0, 1) ? '0 : VW'($urandom_range(1, 4)),
                   1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 8)) send_tick();
      end else if (scen <= 5) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          send_tick();
        else if (pick < 70)
          send_req(dltq_pkg::REQ_ADD, IW'($urandom), rand_ticks(), rand_ticks(),
                   1'($urandom));
        else if (pick < 85)
          send_req(dltq_pkg::REQ_CANCEL, IW'($urandom), $urandom, $urandom, 1'($urandom));
        else
          send_req(dltq_pkg::REQ_GET, IW'($urandom), $urandom, $urandom, 1'($urandom));
      end else if (scen == 6) begin
        // full-width delays, then read back
        id_sel = IW'($urandom);
        send_req(dltq_pkg::REQ_ADD, id_sel, $urandom,
                 $urandom_range(0, 1) ? '0 : VW'($urandom), 1'($urandom));
        send_req(dltq_pkg::REQ_GET, id_sel, '0, '0, 1'b0);
      end else if (scen == 7) begin
        repeat (3) begin
          send_req($urandom_range(0, 1) ? dltq_pkg::REQ_CANCEL : dltq_pkg::REQ_GET,
                   IW'($urandom), '0, '0, 1'b0);
        end
      end else if (scen == 8) begin
        // re-add a listed alarm
        id_sel = IW'($urandom);
        send_req(dltq_pkg::REQ_ADD, id_sel, VW'($urandom_range(1, 8)), rand_ticks(),
                 1'($urandom));
        send_req(dltq_pkg::REQ_ADD, id_sel, rand_ticks(), rand_ticks(), 1'($urandom));
        send_req(dltq_pkg::REQ_GET, id_sel, '0, '0, 1'b0);
      end else begin
        repeat ($urandom_range(3, 10)) send_tick();
      end
    end
    in_valid <= 1'b0;

    // Drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** delta_list_timer_queue: PASSED **");
    else
      $display("** delta_list_timer_queue: FAILED **");
    $finish;
  end

endmodule
